/* sv/rpns_pkg.sv */
package rpns_pkg;

  localparam int POOL_DEPTH_DEF = 16;
  localparam int MAX_PATH_DEF   = 5;

  localparam logic [1:0] KIND_PATH   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_UPDATE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_TOO_FEW   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_RANDOM = 2'd1;
  localparam logic [1:0] MODE_LOWEST = 2'd2;
  localparam logic [1:0] MODE_ROTATE = 2'd3;

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_MODE    = 2'd1;
  localparam logic [1:0] REG_HOPS    = 2'd2;
  localparam logic [1:0] REG_SEED    = 2'd3;

  localparam int CFG_WIDTH = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] node_id;
    logic [31:0] latency;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] chosen_node;
    logic [2:0]  position;
    logic        last;
  } result_t;

endpackage

/* sv/rpns_modred.sv */
module rpns_modred #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [15:0]  dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);
  logic [15:0]  quo;
  logic [W:0]   rem;
  logic [4:0]   cnt;
  logic         run;
  logic [W+1:0] trial;

  assign trial = {rem, quo[15]} - {1'b0, 1'b0, divisor};
  assign remainder = rem[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd0;
        quo <= dividend;
        rem <= '0;
      end else if (run) begin
        quo <= {quo[14:0], 1'b0};
        if (!trial[W+1]) begin
          rem <= trial[W:0];
        end else begin
          rem <= {rem[W-1:0], quo[15]};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* sv/relay_path_node_selector.sv */
// An add or a refused path request gives its result in the cycle after acceptance; a remove or
// update scans the pool entry by entry, and a remove then shifts the later entries down one place.
// A random path request shuffles the pool by drawing an entry for each place but the first, each
// draw using a serial modulo; the other modes finish sooner. One transaction is taken at a time;
// busy is high while one runs and falls with the last result; it stays low for an add or refused path.
// Results appear on result with strobe for one cycle each; the receiver cannot stall. Reset
// (synchronous, active high) empties the pool and restores the register defaults.
module relay_path_node_selector #(
  parameter int POOL_DEPTH = rpns_pkg::POOL_DEPTH_DEF,
  parameter int MAX_PATH   = rpns_pkg::MAX_PATH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  rpns_pkg::item_t        item,
  output logic                   busy,
  output logic                   strobe,
  output rpns_pkg::result_t      result,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [rpns_pkg::CFG_WIDTH-1:0] cfg_data
);
  import rpns_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int SW = $clog2(POOL_DEPTH + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND    = 4'd1;
  localparam logic [3:0] S_SHIFT   = 4'd2;
  localparam logic [3:0] S_INIT    = 4'd3;
  localparam logic [3:0] S_SHDRAW  = 4'd4;
  localparam logic [3:0] S_SHWAIT  = 4'd5;
  localparam logic [3:0] S_SHSWAP  = 4'd6;
  localparam logic [3:0] S_SELRD   = 4'd7;
  localparam logic [3:0] S_SELSCAN = 4'd8;
  localparam logic [3:0] S_SELSWAP = 4'd9;
  localparam logic [3:0] S_OUTRD   = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;
  localparam logic [3:0] S_ROTMOD  = 4'd12;
  localparam logic [3:0] S_SHIFT2  = 4'd13;
  localparam logic [3:0] S_FIND2   = 4'd14;
  localparam logic [3:0] S_SELRD2  = 4'd15;

  logic [15:0] ids [POOL_DEPTH];
  logic [31:0] lats [POOL_DEPTH];
  logic [IW-1:0] order [POOL_DEPTH];

  logic          enabled;
  logic [1:0]    mode;
  logic [2:0]    hops;
  logic [15:0]   lfsr;
  logic [SW-1:0] size;
  logic [IW-1:0] rot;
  logic [3:0]    state;
  item_t         cur;
  logic [SW-1:0] i, j, m;
  logic [3:0]    cnt;
  logic [31:0]   minlat;
  logic [15:0]   rd_id;
  logic [31:0]   rd_lat;
  logic [IW-1:0] rd_ord;

  logic [3:0]    cnt_eff;
  logic          mod_start, mod_done;
  logic [15:0]   mod_a;
  logic [SW-1:0] mod_b, mod_r;
  logic [15:0]   lfsr_step;

  always_comb begin
    cnt_eff = {1'b0, hops};
    if (hops == 3'd0) cnt_eff = 4'd1;
    if (cnt_eff > 4'(MAX_PATH)) cnt_eff = 4'(MAX_PATH);
  end

  assign lfsr_step = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};

  rpns_modred #(.W(SW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(mod_a),
    .divisor(mod_b), .done(mod_done), .remainder(mod_r)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      enabled <= 1'b0;
      mode <= MODE_RANDOM;
      hops <= 3'd2;
      lfsr <= 16'd1;
      size <= '0;
      rot <= '0;
      strobe <= 1'b0;
      mod_start <= 1'b0;
    end else begin
      strobe <= 1'b0;
      mod_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED: enabled <= cfg_data[0];
          REG_MODE: mode <= cfg_data[1:0];
          REG_HOPS: hops <= cfg_data[2:0];
          REG_SEED: lfsr <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= item;
            i <= '0;
            case (item.kind)
              KIND_PATH: begin
                if (!enabled) begin
                  result <= '{ST_DISABLED, 16'd0, 3'd0, 1'b1};
                  strobe <= 1'b1;
                end else if ({1'b0, size} < (SW+1)'(cnt_eff)) begin
                  result <= '{ST_TOO_FEW, 16'd0, 3'd0, 1'b1};
                  strobe <= 1'b1;
                end else begin
                  state <= S_INIT;
                end
              end
              KIND_ADD: begin
                if (size >= SW'(POOL_DEPTH)) begin
                  result <= '{ST_FULL, 16'd0, 3'd0, 1'b1};
                end else begin
                  ids[size[IW-1:0]] <= item.node_id;
                  lats[size[IW-1:0]] <= 32'hFFFF_FFFF;
                  size <= size + 1'b1;
                  result <= '{ST_OK, 16'd0, 3'd0, 1'b1};
                end
                strobe <= 1'b1;
              end
              default: state <= S_FIND;
            endcase
          end
        end
        S_FIND: begin
          if (i >= size) begin
            result <= '{ST_NOT_FOUND, 16'd0, 3'd0, 1'b1};
            strobe <= 1'b1;
            state <= S_IDLE;
          end else begin
            rd_id <= ids[i[IW-1:0]];
            state <= S_FIND2;
          end
        end
        S_FIND2: begin
          if (rd_id == cur.node_id) begin
            if (cur.kind == KIND_UPDATE) begin
              lats[i[IW-1:0]] <= cur.latency;
              result <= '{ST_OK, 16'd0, 3'd0, 1'b1};
              strobe <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_SHIFT;
            end
          end else begin
            i <= i + 1'b1;
            state <= S_FIND;
          end
        end
        S_SHIFT: begin
          if (i + 1'b1 >= size) begin
            size <= size - 1'b1;
            result <= '{ST_OK, 16'd0, 3'd0, 1'b1};
            strobe <= 1'b1;
            state <= S_IDLE;
          end else begin
            rd_id <= ids[i[IW-1:0] + 1'b1];
            rd_lat <= lats[i[IW-1:0] + 1'b1];
            state <= S_SHIFT2;
          end
        end
        S_SHIFT2: begin
          ids[i[IW-1:0]] <= rd_id;
          lats[i[IW-1:0]] <= rd_lat;
          i <= i + 1'b1;
          state <= S_SHIFT;
        end
        S_INIT: begin
          order[i[IW-1:0]] <= i[IW-1:0];
          if (i + 1'b1 >= size) begin
            case (mode)
              MODE_RANDOM: begin
                i <= size - 1'b1;
                state <= S_SHDRAW;
              end
              MODE_LOWEST: begin
                i <= '0;
                state <= S_SELRD;
              end
              MODE_ROTATE: begin
                mod_a <= 16'(rot);
                mod_b <= size;
                mod_start <= 1'b1;
                state <= S_ROTMOD;
              end
              default: begin
                cnt <= '0;
                state <= S_OUTRD;
              end
            endcase
          end else begin
            i <= i + 1'b1;
          end
        end
        S_ROTMOD: begin
          if (mod_done) begin
            rot <= mod_r[IW-1:0];
            cnt <= '0;
            i <= '0;
            state <= S_OUTRD;
          end
        end
        S_SHDRAW: begin
          if (i == '0) begin
            cnt <= '0;
            state <= S_OUTRD;
          end else begin
            lfsr <= lfsr_step;
            mod_a <= lfsr_step;
            mod_b <= i + 1'b1;
            mod_start <= 1'b1;
            state <= S_SHWAIT;
          end
        end
        S_SHWAIT: begin
          if (mod_done) begin
            j <= mod_r;
            state <= S_SHSWAP;
          end
        end
        S_SHSWAP: begin
          order[i[IW-1:0]] <= order[j[IW-1:0]];
          order[j[IW-1:0]] <= order[i[IW-1:0]];
          i <= i - 1'b1;
          state <= S_SHDRAW;
        end
        S_SELRD: begin
          if (i >= SW'(cnt_eff)) begin
            cnt <= '0;
            state <= S_OUTRD;
          end else begin
            m <= i;
            j <= i + 1'b1;
            minlat <= lats[order[i[IW-1:0]]];
            state <= S_SELSCAN;
          end
        end
        S_SELSCAN: begin
          if (j >= size) begin
            state <= S_SELSWAP;
          end else begin
            rd_lat <= lats[order[j[IW-1:0]]];
            state <= S_SELRD2;
          end
        end
        S_SELRD2: begin
          if (rd_lat < minlat) begin
            minlat <= rd_lat;
            m <= j;
          end
          j <= j + 1'b1;
          state <= S_SELSCAN;
        end
        S_SELSWAP: begin
          order[i[IW-1:0]] <= order[m[IW-1:0]];
          order[m[IW-1:0]] <= order[i[IW-1:0]];
          i <= i + 1'b1;
          state <= S_SELRD;
        end
        S_OUTRD: begin
          if (mode == MODE_ROTATE) begin
            rd_ord <= rot;
            if (SW'(rot) + 1'b1 >= size) rot <= '0;
            else rot <= rot + 1'b1;
          end else begin
            rd_ord <= order[cnt[IW-1:0]];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          result <= '{ST_OK, ids[rd_ord], cnt[2:0], (cnt + 4'd1 == cnt_eff)};
          strobe <= 1'b1;
          if (cnt + 4'd1 == cnt_eff) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 4'd1;
            state <= S_OUTRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* tb/relay_path_node_selector_checker.sv */
module relay_path_node_selector_checker
  import rpns_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  item_t                 item,
  input  logic                  strobe,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_WIDTH-1:0]  cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = POOL_DEPTH_DEF;
  localparam int HOPS_MAX = MAX_PATH_DEF;

  logic [15:0] pool_id [DEPTH];
  logic [31:0] pool_lat [DEPTH];
  int          pool_count;
  int          rotate_pos;
  logic [15:0] shuffle_lfsr;
  logic        path_enabled;
  logic [1:0]  path_mode;
  logic [2:0]  path_hops;
  result_t     awaited [$];

  assign pending = awaited.size();

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_result(input logic [2:0] st, input logic [15:0] node,
                             input logic [2:0] pos, input logic fin);
    result_t r;
    r.status = st;
    r.chosen_node = node;
    r.position = pos;
    r.last = fin;
    awaited.push_back(r);
  endtask

  task automatic step_lfsr();
    logic b;
    b = shuffle_lfsr[0] ^ shuffle_lfsr[2] ^ shuffle_lfsr[3] ^ shuffle_lfsr[5];
    shuffle_lfsr = {b, shuffle_lfsr[15:1]};
  endtask

  task automatic predict_path();
    int order [DEPTH];
    int cnt;
    int j;
    int m;
    int t;
    if (!path_enabled) begin
      push_result(ST_DISABLED, 16'd0, 3'd0, 1'b1);
      return;
    end
    cnt = path_hops;
    if (cnt == 0) cnt = 1;
    if (cnt > HOPS_MAX) cnt = HOPS_MAX;
    if (pool_count < cnt) begin
      push_result(ST_TOO_FEW, 16'd0, 3'd0, 1'b1);
      return;
    end
    for (int i = 0; i < DEPTH; i++) order[i] = i;
    case (path_mode)
      MODE_RANDOM: begin
        for (int i = pool_count - 1; i > 0; i--) begin
          step_lfsr();
          j = int'(shuffle_lfsr) % (i + 1);
          t = order[i]; order[i] = order[j]; order[j] = t;
        end
      end
      MODE_LOWEST: begin
        for (int i = 0; i < cnt; i++) begin
          m = i;
          for (int k = i + 1; k < pool_count; k++)
            if (pool_lat[order[k]] < pool_lat[order[m]]) m = k;
          t = order[i]; order[i] = order[m]; order[m] = t;
        end
      end
      MODE_ROTATE: begin
        for (int i = 0; i < cnt; i++) order[i] = (rotate_pos + i) % pool_count;
        rotate_pos = (rotate_pos + cnt) % pool_count;
      end
      default: ;
    endcase
    for (int i = 0; i < cnt; i++)
      push_result(ST_OK, pool_id[order[i]], 3'(i), i + 1 == cnt);
  endtask

  task automatic predict_item(input item_t it);
    int p;
    p = -1;
    if (it.kind == KIND_PATH) begin
      predict_path();
      return;
    end
    if (it.kind == KIND_ADD) begin
      if (pool_count >= DEPTH) begin
        push_result(ST_FULL, 16'd0, 3'd0, 1'b1);
      end else begin
        pool_id[pool_count] = it.node_id;
        pool_lat[pool_count] = 32'hFFFF_FFFF;
        pool_count++;
        push_result(ST_OK, 16'd0, 3'd0, 1'b1);
      end
      return;
    end
    for (int i = pool_count - 1; i >= 0; i--)
      if (pool_id[i] == it.node_id) p = i;
    if (p < 0) begin
      push_result(ST_NOT_FOUND, 16'd0, 3'd0, 1'b1);
      return;
    end
    if (it.kind == KIND_REMOVE) begin
      for (int i = p; i + 1 < pool_count; i++) begin
        pool_id[i] = pool_id[i + 1];
        pool_lat[i] = pool_lat[i + 1];
      end
      pool_count--;
    end else begin
      pool_lat[p] = it.latency;
    end
    push_result(ST_OK, 16'd0, 3'd0, 1'b1);
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      pool_count = 0;
      rotate_pos = 0;
      shuffle_lfsr = 16'd1;
      path_enabled = 1'b0;
      path_mode = MODE_RANDOM;
      path_hops = 3'd2;
      awaited.delete();
    end else begin
      if (strobe) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", result));
        end else begin
          exp_r = awaited.pop_front();
          if (result.status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, exp_r.status));
          if (result.chosen_node !== exp_r.chosen_node)
            report_mismatch($sformatf("chosen_node %h, expected %h",
                                      result.chosen_node, exp_r.chosen_node));
          if (result.position !== exp_r.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      result.position, exp_r.position));
          if (result.last !== exp_r.last)
            report_mismatch($sformatf("last %b, expected %b", result.last, exp_r.last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED: path_enabled = cfg_data[0];
          REG_MODE:    path_mode = cfg_data[1:0];
          REG_HOPS:    path_hops = cfg_data[2:0];
          REG_SEED:    shuffle_lfsr = (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_item(item);
    end
  end

  initial errors = 0;
endmodule

/* tb/relay_path_node_selector_test.sv */
module relay_path_node_selector_test;
  import rpns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  item_t                item = '0;
  logic                 busy;
  logic                 strobe;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = REG_ENABLED;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   quiet_cycles = 0;
  bit                   steady = 1'b0;

  always #5 clk = ~clk;

  relay_path_node_selector dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  relay_path_node_selector_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [15:0] id, input logic [31:0] lat);
    if (!steady && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item <= '{kind: kind, node_id: id, latency: lat};
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [15:0] id;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
    if (pick < 35) send(KIND_PATH, 16'($urandom), $urandom);
    else if (pick < 62) send(KIND_ADD, id, $urandom);
    else if (pick < 81) send(KIND_REMOVE, id, $urandom);
    else send(KIND_UPDATE, id, $urandom);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(KIND_PATH, 16'd0, 32'd0);
    send(KIND_REMOVE, 16'd5, 32'd0);
    send(KIND_UPDATE, 16'hFFFF, 32'd7);
    drain();
    write_reg(REG_ENABLED, 16'd1);
    write_reg(REG_SEED, 16'd0);
    send(KIND_PATH, 16'd0, 32'd0);
    send(KIND_ADD, 16'h0000, 32'd0);
    send(KIND_ADD, 16'hFFFF, 32'd0);
    for (int i = 2; i < 16; i++) send(KIND_ADD, 16'(i % 10), 32'd0);
    send(KIND_ADD, 16'h1234, 32'd0);
    send(KIND_UPDATE, 16'hFFFF, 32'd0);
    send(KIND_UPDATE, 16'd3, 32'hFFFF_FFFE);
    send(KIND_UPDATE, 16'd5, 32'h8000_0000);
    send(KIND_REMOVE, 16'd4, 32'd0);
    drain();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, 16'(m));
      write_reg(REG_HOPS, (m % 2) ? 16'd7 : 16'd0);
      send(KIND_PATH, 16'd0, 32'd0);
      drain();
      write_reg(REG_HOPS, 16'd5);
      send(KIND_PATH, 16'd0, 32'd0);
      drain();
    end

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_ENABLED, (ph == 3) ? 16'd0 : 16'd1);
      write_reg(REG_MODE, 16'(ph % 4));
      write_reg(REG_HOPS, 16'($urandom_range(0, 7)));
      write_reg(REG_SEED, (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'd1 : 16'($urandom));
      steady = (ph == 4);
      for (int n = 0; n < 48; n++) random_item();
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
